FILE: rtl/dle_pkg.sv
// Package for the DLE/ETX deframer: sync state encoding and register indexes.
// No dependencies; imported by dle_etx_frame_deframer.
`timescale 1ns / 1ps
`default_nettype none

package dle_pkg;

    // Register indexes on the write port
    localparam int unsigned REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_ESCAPE_CODE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_END_CODE    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ENABLE      = 2'd2;

    // Reset values of the configuration registers
    localparam logic [7:0] ESCAPE_CODE_RST = 8'h10;
    localparam logic [7:0] END_CODE_RST    = 8'h03;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    typedef enum logic [2:0] {
        ST_SEEK_PLAIN = 3'd0,
        ST_SEEK_ESC   = 3'd1,
        ST_SEEK_END   = 3'd2,
        ST_IDLE       = 3'd3,
        ST_BODY       = 3'd4,
        ST_BODY_ESC   = 3'd5
    } sync_state_t;

endpackage : dle_pkg

`default_nettype wire

FILE: rtl/dle_etx_frame_deframer.sv
// DLE/ETX deframer top level: sync state machine, frame counter, result register.
// Depends on dle_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The deframer takes one received byte per request on the input channel and
// strips DLE/ETX framing. After reset it resynchronises: it waits for a byte
// that is neither escape nor end code, then for an escape directly followed
// by an end code; from then on an escape opens a frame. Inside a frame a
// doubled escape gives one escape payload byte, escape then end code closes
// the frame, and escape then any other byte gives that byte. Each kept
// payload byte leaves as a request with kind 0 and its index in the frame;
// the frame end leaves as a request with kind 1, the kept length and an
// overflow flag. Payload bytes past FRAME_CAPACITY are dropped and flagged.
// Rate: one byte per clock cycle while results are taken; each result is
// registered in the cycle after acceptance. All the decoding is one state
// transition and one counter increment between the input handshake and the
// output register; in_ready falls only while that register holds a result
// that the consumer is not taking. Configuration writes take effect from the
// next byte; with enable at 0 bytes are accepted and dropped. There is no
// clearing pass after reset.
module dle_etx_frame_deframer
    import dle_pkg::*;
#(
    parameter int unsigned FRAME_CAPACITY = 256
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    // configuration write port
    input  wire logic                 wr_en,
    input  wire logic [REG_IDX_W-1:0] wr_index,
    input  wire logic [7:0]           wr_data,

    // received bytes
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           rx_byte,

    // deframed results
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      kind,
    output logic [7:0]                data_byte,
    output logic [7:0]                byte_index,
    output logic [8:0]                frame_length,
    output logic                      overflow
);

    // Counter holds 0..FRAME_CAPACITY inclusive
    localparam int unsigned CNT_W = $clog2(FRAME_CAPACITY + 1);
    localparam int unsigned EXT_W = CNT_W + 9;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(FRAME_CAPACITY);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0] escape_code_reg;
    logic [7:0] end_code_reg;
    logic       enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_code_reg <= ESCAPE_CODE_RST;
            end_code_reg    <= END_CODE_RST;
            enable_reg      <= 1'b1;
        end
        else if (wr_en)
        begin
            // an index beyond the list falls through and is ignored
            unique case (wr_index)
                REG_ESCAPE_CODE: escape_code_reg <= wr_data;
                REG_END_CODE:    end_code_reg    <= wr_data;
                REG_ENABLE:      enable_reg      <= wr_data[0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic in_accept;
    logic step;

    // Take a new byte whenever the result register is empty or being drained
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    // A byte only moves the state when the block is enabled
    assign step      = in_accept && enable_reg;

    // ------------------------------------------------------------------
    // Sync state machine and frame counter
    // ------------------------------------------------------------------
    sync_state_t      state_reg, state_next;
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic             overflow_seen_reg, overflow_seen_next;

    logic             is_esc, is_end, is_full;
    logic             emit;
    logic             kind_next;
    logic [7:0]       data_byte_next;
    logic [7:0]       byte_index_next;
    logic [8:0]       frame_length_next;
    logic             overflow_next;
    logic [EXT_W-1:0] count_ext;

    assign is_esc    = (rx_byte == escape_code_reg);
    assign is_end    = (rx_byte == end_code_reg);
    assign is_full   = (byte_count_reg >= CAP);
    // Widen before slicing so that small capacities zero-fill the fields
    assign count_ext = EXT_W'(byte_count_reg);

    always_comb
    begin
        state_next         = state_reg;
        byte_count_next    = byte_count_reg;
        overflow_seen_next = overflow_seen_reg;
        emit               = 1'b0;
        kind_next          = KIND_PAYLOAD;
        data_byte_next     = rx_byte;
        byte_index_next    = count_ext[7:0];
        frame_length_next  = 9'd0;
        overflow_next      = 1'b0;

        if (step)
        begin
            unique case (state_reg)
                ST_SEEK_PLAIN:
                begin
                    if (!is_esc && !is_end)
                        state_next = ST_SEEK_ESC;
                end
                ST_SEEK_ESC:
                begin
                    if (is_esc)
                        state_next = ST_SEEK_END;
                end
                ST_SEEK_END:
                begin
                    state_next = is_end ? ST_IDLE : ST_SEEK_ESC;
                end
                ST_IDLE:
                begin
                    if (is_esc)
                        state_next = ST_BODY_ESC;
                end
                ST_BODY:
                begin
                    // escape test first, so equal codes count as escape here
                    if (is_esc)
                        state_next = ST_BODY_ESC;
                    else if (is_full)
                        overflow_seen_next = 1'b1;
                    else
                    begin
                        emit            = 1'b1;
                        byte_count_next = byte_count_reg + CNT_W'(1);
                    end
                end
                ST_BODY_ESC:
                begin
                    // end code test first after an escape
                    if (is_end)
                    begin
                        emit               = 1'b1;
                        kind_next          = KIND_END;
                        data_byte_next     = 8'd0;
                        byte_index_next    = 8'd0;
                        frame_length_next  = count_ext[8:0];
                        overflow_next      = overflow_seen_reg;
                        byte_count_next    = '0;
                        overflow_seen_next = 1'b0;
                        state_next         = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_BODY;
                        if (is_full)
                            overflow_seen_next = 1'b1;
                        else
                        begin
                            emit            = 1'b1;
                            byte_count_next = byte_count_reg + CNT_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_next = ST_SEEK_PLAIN;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_SEEK_PLAIN;
            byte_count_reg    <= '0;
            overflow_seen_reg <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            byte_count_reg    <= byte_count_next;
            overflow_seen_reg <= overflow_seen_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic       out_valid_next;
    logic       kind_reg;
    logic [7:0] data_byte_reg;
    logic [7:0] byte_index_reg;
    logic [8:0] frame_length_reg;
    logic       overflow_reg;

    always_comb
    begin
        priority if (in_accept)
            out_valid_next = emit;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Load payload only with a fresh result; hold it while stalled
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg         <= kind_next;
            data_byte_reg    <= data_byte_next;
            byte_index_reg   <= byte_index_next;
            frame_length_reg <= frame_length_next;
            overflow_reg     <= overflow_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign data_byte    = data_byte_reg;
    assign byte_index   = byte_index_reg;
    assign frame_length = frame_length_reg;
    assign overflow     = overflow_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= CAP)
        else $error("frame counter above capacity");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_seen_reg |-> byte_count_reg == CAP)
        else $error("overflow flagged with room left in the frame");

    a_outside_frame_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEEK_PLAIN || state_reg == ST_SEEK_ESC ||
         state_reg == ST_SEEK_END || state_reg == ST_IDLE)
        |-> (byte_count_reg == '0 && !overflow_seen_reg))
        else $error("frame state left over outside a frame");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && kind_next == KIND_END) |=>
        (state_reg == ST_IDLE && byte_count_reg == '0 && out_valid_reg))
        else $error("frame end did not clear the counter");

    a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_END) |->
        (data_byte_reg == 8'd0 && byte_index_reg == 8'd0))
        else $error("end marker carries payload fields");

endmodule : dle_etx_frame_deframer

`default_nettype wire
